### design/nv21y_pkg.sv
// shared constants, register codes and the dimension clamp for the nv21 chroma split block
// no dependencies; used by nv21_to_yuv444_split
package nv21y_pkg;

  localparam int unsigned DIM_W          = 11;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned PIX_IDX_W      = 20;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register index is byte address bit 2
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // even dimension, at least 2, at most the even part of maxv
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input int unsigned maxv);
    logic [DIM_W-1:0] d;
    int unsigned      m;
    d = r & ~DIM_W'(1);
    m = maxv & ~32'd1;
    if (d < DIM_W'(2)) begin
      d = DIM_W'(2);
    end
    if (32'(d) > m) begin
      d = DIM_W'(m);
    end
    return d;
  endfunction

endpackage

### design/nv21_to_yuv444_split.sv
// NV21 byte stream to 4:4:4 pixels: luma memory, position tracking, pixel read sequencer
// and a two-entry output queue; depends on nv21y_pkg
//
// Bytes of one NV21 frame enter one per request: width*height luma bytes, written to an
// on-chip luma memory of MAX_WIDTH*MAX_HEIGHT bytes, then V,U pairs. Luma bytes are taken
// one per cycle. Each U byte starts four reads of the single luma read port, one per
// cycle, and gives the four pixels of its 2x2 block in raster order. The request after a
// U byte is taken no earlier than the last of those reads, so pixels leave at one per
// cycle while the output does not stall. The read port is the limit. The first pixel of
// a U request passes the read register and the output queue before it can leave; output
// stalls that fill the queue hold off further reads and U requests. After reset and after
// every register write the block recomputes the frame size in states ST_DIM, ST_SIZE,
// ST_TOTAL and ST_CHECK, with input stalled (the write cycle itself also stalls input);
// if the kept position lies inside the chroma plane it then runs a restoring divide, one
// quotient bit a cycle, and rebuilds the read address in states ST_MUL and ST_BASE. The
// luma memory is not cleared.
module nv21_to_yuv444_split #(
  parameter int unsigned MAX_WIDTH  = nv21y_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = nv21y_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nv21y_pkg::APB_AW-1:0]        paddr,
  input  logic [nv21y_pkg::APB_DW-1:0]        pwdata,
  output logic [nv21y_pkg::APB_DW-1:0]        prdata,
  output logic                                pready,
  // byte stream in
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [nv21y_pkg::BYTE_W-1:0]        data_byte_i,
  // pixels out
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [nv21y_pkg::PIX_IDX_W-1:0]     pixel_index_o,
  output logic [nv21y_pkg::BYTE_W-1:0]        luma_o,
  output logic [nv21y_pkg::BYTE_W-1:0]        chroma_u_o,
  output logic [nv21y_pkg::BYTE_W-1:0]        chroma_v_o,
  output logic                                last_of_run_o,
  output logic                                frame_done_o
);

  localparam int unsigned DW    = nv21y_pkg::DIM_W;
  localparam int unsigned BW    = nv21y_pkg::BYTE_W;
  localparam int unsigned STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(STORE);
  localparam int unsigned PW    = $clog2(STORE + STORE / 2 + 1);
  localparam int unsigned QW    = PW - 1;
  localparam int unsigned CW    = DW - 1;
  localparam int unsigned DCW   = $clog2(QW + 1);
  localparam int unsigned IXW   = (AW > nv21y_pkg::PIX_IDX_W) ? AW : nv21y_pkg::PIX_IDX_W;

  typedef enum logic [2:0] {
    ST_DIM,
    ST_SIZE,
    ST_TOTAL,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_BASE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [AW-1:0] idx;
    logic [BW-1:0] y;
    logic [BW-1:0] u;
    logic [BW-1:0] v;
    logic          last;
    logic          done;
  } pix_t;

  // configuration registers
  logic [DW-1:0] width_q, height_q;
  logic          cfg_we;

  // sequencer state
  state_e          state_q;
  logic [DW-1:0]   w_q, h_q;
  logic [PW-1:0]   fsize_q, total_q, pos_q;
  logic [BW-1:0]   held_v_q;
  logic [CW-1:0]   ccol_q;
  logic [AW-1:0]   idx0_q;
  logic [QW-1:0]   div_num_q;
  logic [CW-1:0]   div_rem_q;
  logic [DCW-1:0]  div_cnt_q;
  logic [AW-1:0]   prod_q;
  logic            gen_busy_q;
  logic [1:0]      gen_k_q;

  // pixel payload
  logic [AW-1:0]   gen_base_q;
  logic [BW-1:0]   gen_u_q, gen_v_q;
  logic            gen_done_q;
  logic            s1_valid_q;
  logic [AW-1:0]   s1_idx_q;
  logic [BW-1:0]   s1_u_q, s1_v_q;
  logic            s1_last_q, s1_done_q;

  // luma memory
  logic [BW-1:0]   luma_mem [STORE];
  logic [BW-1:0]   rdata_q;

  // output queue
  pix_t            fifo_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  pix_t            head;

  // combinational
  logic            pop, issue_ok, run, in_luma, is_u, gen_last, gen_issue;
  logic            can_accept, acc, acc_u, issue, pix_done, at_row_end;
  logic [2:0]      occ;
  logic [AW-1:0]   gen_off, rd_addr;
  logic [PW-1:0]   next_pos;
  logic [CW:0]     rem_sh, half_x;
  logic            q_bit;
  logic [2*DW-1:0] dim_prod;
  logic [QW+DW-1:0] prod_full;
  logic [IXW-1:0]  head_idx_w;

  // ---------------------------------------------------------------- configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (nv21y_pkg::reg_idx_e'(paddr[2]))
      nv21y_pkg::REG_WIDTH:  prdata = nv21y_pkg::APB_DW'(width_q);
      nv21y_pkg::REG_HEIGHT: prdata = nv21y_pkg::APB_DW'(height_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= nv21y_pkg::WIDTH_RST;
      height_q <= nv21y_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (nv21y_pkg::reg_idx_e'(paddr[2]))
        nv21y_pkg::REG_WIDTH:  width_q  <= pwdata[DW-1:0];
        nv21y_pkg::REG_HEIGHT: height_q <= pwdata[DW-1:0];
        default:               width_q  <= width_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- request control
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign occ         = {1'b0, cnt_q} + {2'b00, s1_valid_q};
  // a read may start only if its pixel is sure to find room in the queue
  assign issue_ok    = (occ < 3'd2) || ((occ == 3'd2) && pop);

  assign run        = (state_q == ST_RUN);
  assign in_luma    = (pos_q < fsize_q);
  assign is_u       = ~in_luma & pos_q[0];
  assign gen_last   = (gen_k_q == 2'd3);
  assign gen_issue  = gen_busy_q & issue_ok;

  // a U request needs the read port; other requests may overlap the last read only
  assign can_accept = run && !cfg_we &&
                      (is_u ? (!gen_busy_q && issue_ok)
                            : (!gen_busy_q || (gen_last && issue_ok)));
  assign in_stall_o = ~can_accept;
  assign acc        = in_valid_i & can_accept;
  assign acc_u      = acc & is_u;
  assign issue      = gen_issue | acc_u;

  assign next_pos   = pos_q + PW'(1);
  assign pix_done   = (next_pos == total_q);
  assign at_row_end = (ccol_q == (w_q[DW-1:1] - CW'(1)));

  always_comb begin
    unique case (gen_k_q)
      2'd1:    gen_off = AW'(1);
      2'd2:    gen_off = AW'(w_q);
      2'd3:    gen_off = AW'(w_q) + AW'(1);
      default: gen_off = '0;
    endcase
  end

  assign rd_addr = acc_u ? idx0_q : (gen_base_q + gen_off);

  // ---------------------------------------------------------------- resync datapath
  assign dim_prod  = w_q * h_q;
  assign prod_full = div_num_q * w_q;
  assign half_x    = {1'b0, w_q[DW-1:1]};
  assign rem_sh    = {div_rem_q, div_num_q[QW-1]};
  assign q_bit     = (rem_sh >= half_x);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_DIM;
      w_q        <= '0;
      h_q        <= '0;
      fsize_q    <= '0;
      total_q    <= '0;
      pos_q      <= '0;
      held_v_q   <= '0;
      ccol_q     <= '0;
      idx0_q     <= '0;
      div_num_q  <= '0;
      div_rem_q  <= '0;
      div_cnt_q  <= '0;
      prod_q     <= '0;
    end else if (cfg_we) begin
      state_q <= ST_DIM;
    end else begin
      unique case (state_q)
        ST_DIM: begin
          w_q     <= nv21y_pkg::eff_dim(width_q, MAX_WIDTH);
          h_q     <= nv21y_pkg::eff_dim(height_q, MAX_HEIGHT);
          state_q <= ST_SIZE;
        end
        ST_SIZE: begin
          fsize_q <= PW'(dim_prod);
          state_q <= ST_TOTAL;
        end
        ST_TOTAL: begin
          total_q <= fsize_q + (fsize_q >> 1);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (pos_q >= total_q) begin
            pos_q   <= '0;
            ccol_q  <= '0;
            idx0_q  <= '0;
            state_q <= ST_RUN;
          end else if (pos_q < fsize_q) begin
            ccol_q  <= '0;
            idx0_q  <= '0;
            state_q <= ST_RUN;
          end else begin
            // chroma pair number, split into row and column by the divide
            div_num_q <= QW'((pos_q - fsize_q) >> 1);
            div_rem_q <= '0;
            div_cnt_q <= DCW'(QW);
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_num_q <= {div_num_q[QW-2:0], q_bit};
          div_rem_q <= q_bit ? CW'(rem_sh - half_x) : rem_sh[CW-1:0];
          div_cnt_q <= div_cnt_q - DCW'(1);
          if (div_cnt_q == DCW'(1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_full[AW-1:0];
          ccol_q  <= div_rem_q;
          state_q <= ST_BASE;
        end
        ST_BASE: begin
          idx0_q  <= AW'({prod_q, 1'b0}) + AW'({div_rem_q, 1'b0});
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (acc) begin
            if (in_luma) begin
              pos_q <= next_pos;
            end else if (!is_u) begin
              held_v_q <= data_byte_i;
              pos_q    <= next_pos;
            end else if (pix_done) begin
              pos_q  <= '0;
              ccol_q <= '0;
              idx0_q <= '0;
            end else begin
              pos_q <= next_pos;
              if (at_row_end) begin
                // skip the odd row of this block pair
                ccol_q <= '0;
                idx0_q <= idx0_q + AW'(w_q) + AW'(2);
              end else begin
                ccol_q <= ccol_q + CW'(1);
                idx0_q <= idx0_q + AW'(2);
              end
            end
          end
        end
        default: state_q <= ST_DIM;
      endcase
    end
  end

  // read sequencer for the three pixels after the first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_busy_q <= 1'b0;
      gen_k_q    <= 2'd0;
    end else if (acc_u) begin
      gen_busy_q <= 1'b1;
      gen_k_q    <= 2'd1;
    end else if (gen_issue) begin
      if (gen_last) begin
        gen_busy_q <= 1'b0;
        gen_k_q    <= 2'd0;
      end else begin
        gen_k_q <= gen_k_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_u) begin
      gen_base_q <= idx0_q;
      gen_u_q    <= data_byte_i;
      gen_v_q    <= held_v_q;
      gen_done_q <= pix_done;
    end
  end

  // ---------------------------------------------------------------- luma memory
  always_ff @(posedge clk_i) begin
    if (acc && in_luma) begin
      luma_mem[pos_q[AW-1:0]] <= data_byte_i;
    end
    if (issue) begin
      rdata_q <= luma_mem[rd_addr];
    end
  end

  // side data travelling with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_u) begin
      s1_idx_q  <= idx0_q;
      s1_u_q    <= data_byte_i;
      s1_v_q    <= held_v_q;
      s1_last_q <= 1'b0;
      s1_done_q <= 1'b0;
    end else if (gen_issue) begin
      s1_idx_q  <= rd_addr;
      s1_u_q    <= gen_u_q;
      s1_v_q    <= gen_v_q;
      s1_last_q <= gen_last;
      s1_done_q <= gen_last & gen_done_q;
    end
  end

  // ---------------------------------------------------------------- output queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (s1_valid_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(s1_valid_q) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= '{idx: s1_idx_q, y: rdata_q, u: s1_u_q, v: s1_v_q,
                            last: s1_last_q, done: s1_done_q};
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign head_idx_w    = IXW'(head.idx);
  assign pixel_index_o = head_idx_w[nv21y_pkg::PIX_IDX_W-1:0];
  assign luma_o        = head.y;
  assign chroma_u_o    = head.u;
  assign chroma_v_o    = head.v;
  assign last_of_run_o = head.last;
  assign frame_done_o  = head.done;

  // ---------------------------------------------------------------- assertions
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + {2'b00, s1_valid_q}) <= 3'd2)
    else $error("output queue overcommitted");

  a_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (state_q == ST_RUN))
    else $error("request taken during resync");

  a_u_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_u |-> (!gen_busy_q && issue_ok))
    else $error("U request while read port busy");

  a_read_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> s1_valid_q)
    else $error("luma read lost its side data");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> last_of_run_o)
    else $error("frame end not on a block's last pixel");

endmodule
